FILE: rtl/core/tptf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Three-phase TRIAC firing: shared package
// Types, codes, reset values and timer width used across the block.
// ---------------------------------------------------------------------------
package tptf_pkg;

	localparam int unsigned TimerBits = 16;

	typedef logic [TimerBits-1:0] timer_t;

	typedef enum logic [1:0] {
		CMD_TICK       = 2'd0,
		CMD_ZERO_CROSS = 2'd1,
		CMD_POT_SAMPLE = 2'd2
	} cmd_t;

	localparam logic [1:0] CFG_PULSE_WIDTH = 2'd0;
	localparam logic [1:0] CFG_MIN_DELAY   = 2'd1;
	localparam logic [1:0] CFG_MAX_DELAY   = 2'd2;

	localparam logic [1:0] PHASE_NONE = 2'd0;

	localparam logic [7:0] PULSE_WIDTH_RST  = 8'd4;
	localparam logic [7:0] MIN_DELAY_RST    = 8'd3;
	localparam logic [7:0] MAX_DELAY_RST    = 8'd240;
	localparam logic [7:0] FIRING_DELAY_RST = 8'd100;
	localparam timer_t     COMPARE_A_RST    = timer_t'(255);

	typedef struct packed {
		logic [7:0] pulse_width;
		logic [7:0] min_delay;
		logic [7:0] max_delay;
	} cfg_t;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] phase_id;
		logic [9:0] pot_sample;
	} item_t;

	typedef struct packed {
		logic       gate_one;
		logic       gate_two;
		logic       gate_three;
		logic [7:0] delay_in_use;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/core/tptf_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Three-phase TRIAC firing: channel interfaces
// Command channel into the block and result channel out of it.
// ---------------------------------------------------------------------------
interface tptf_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [1:0] phase_id;
	logic [9:0] pot_sample;

	modport source (output valid, command, phase_id, pot_sample, input ready);
	modport sink   (input valid, command, phase_id, pot_sample, output ready);
endinterface

interface tptf_res_if;
	logic       valid;
	logic       ready;
	logic       gate_one;
	logic       gate_two;
	logic       gate_three;
	logic [7:0] delay_in_use;

	modport source (output valid, gate_one, gate_two, gate_three, delay_in_use, input ready);
	modport sink   (input valid, gate_one, gate_two, gate_three, delay_in_use, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tptf_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Three-phase TRIAC firing: configuration registers
// Pulse width and delay clamps, written through a plain write port.
// ---------------------------------------------------------------------------
module tptf_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [1:0]    index,
	input  wire logic [7:0]    data,
	output tptf_pkg::cfg_t     cfg
);

	tptf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_width <= tptf_pkg::PULSE_WIDTH_RST;
			cfg_q.min_delay   <= tptf_pkg::MIN_DELAY_RST;
			cfg_q.max_delay   <= tptf_pkg::MAX_DELAY_RST;
		end else if (we) begin
			unique case (index)
				tptf_pkg::CFG_PULSE_WIDTH: cfg_q.pulse_width <= data;
				tptf_pkg::CFG_MIN_DELAY:   cfg_q.min_delay   <= data;
				tptf_pkg::CFG_MAX_DELAY:   cfg_q.max_delay   <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/core/tptf_fire_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Three-phase TRIAC firing: state update
// Timer, compare channels A and B, phase queue, gates and firing delay;
// applies one command per enabled cycle and presents the resulting levels.
// ---------------------------------------------------------------------------
module tptf_fire_step (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire tptf_pkg::item_t item,
	input  wire tptf_pkg::cfg_t  cfg,
	output tptf_pkg::result_t    result
);

	tptf_pkg::timer_t tick_q, tick_n;
	tptf_pkg::timer_t cmp_a_q, cmp_a_n;
	tptf_pkg::timer_t cmp_b_q, cmp_b_n;
	logic             next_b_q, next_b_n;
	logic             pulse_a_q, pulse_a_n;
	logic             pulse_b_q, pulse_b_n;
	logic [1:0]       front_q, front_n;
	logic [1:0]       back_q, back_n;
	logic [2:0]       gates_q, gates_n;
	logic [7:0]       delay_q, delay_n;

	always_comb begin
		logic [1:0]       gate_a_idx;
		logic [1:0]       gate_b_idx;
		logic [7:0]       clamp;
		tptf_pkg::timer_t pw_ext;
		tptf_pkg::timer_t delay_ext;

		tick_n    = tick_q;
		cmp_a_n   = cmp_a_q;
		cmp_b_n   = cmp_b_q;
		next_b_n  = next_b_q;
		pulse_a_n = pulse_a_q;
		pulse_b_n = pulse_b_q;
		front_n   = front_q;
		back_n    = back_q;
		gates_n   = gates_q;
		delay_n   = delay_q;
		pw_ext    = tptf_pkg::timer_t'(cfg.pulse_width);
		delay_ext = tptf_pkg::timer_t'(delay_q);
		gate_a_idx = 2'd0;
		gate_b_idx = 2'd0;
		clamp      = item.pot_sample[9:2];

		unique case (tptf_pkg::cmd_t'(item.command))
			tptf_pkg::CMD_TICK: begin
				tick_n = tick_q + 1'b1;
				if (tick_n == cmp_a_q) begin
					pulse_a_n = !pulse_a_q;
					if (front_n != tptf_pkg::PHASE_NONE) begin
						gate_a_idx = front_n - 2'd1;
						gates_n[gate_a_idx] = pulse_a_n;
					end
					if (pulse_a_n) begin
						cmp_a_n = tick_n + pw_ext;
					end else begin
						front_n = back_n;
						back_n  = tptf_pkg::PHASE_NONE;
					end
				end
				if (tick_n == cmp_b_q) begin
					pulse_b_n = !pulse_b_q;
					if (front_n != tptf_pkg::PHASE_NONE) begin
						gate_b_idx = front_n - 2'd1;
						gates_n[gate_b_idx] = pulse_b_n;
					end
					if (pulse_b_n) begin
						cmp_b_n = tick_n + pw_ext;
					end else begin
						front_n = back_n;
						back_n  = tptf_pkg::PHASE_NONE;
					end
				end
			end
			tptf_pkg::CMD_ZERO_CROSS: begin
				if (item.phase_id != tptf_pkg::PHASE_NONE) begin
					if (front_q != tptf_pkg::PHASE_NONE) begin
						back_n = item.phase_id;
					end else begin
						front_n = item.phase_id;
					end
					if (next_b_q) begin
						cmp_b_n = tick_q + delay_ext;
					end else begin
						cmp_a_n = tick_q + delay_ext;
					end
					next_b_n = !next_b_q;
				end
			end
			tptf_pkg::CMD_POT_SAMPLE: begin
				if (clamp < cfg.min_delay) clamp = cfg.min_delay;
				if (clamp > cfg.max_delay) clamp = cfg.max_delay;
				delay_n = clamp;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			cmp_a_q   <= tptf_pkg::COMPARE_A_RST;
			cmp_b_q   <= '0;
			next_b_q  <= 1'b0;
			pulse_a_q <= 1'b0;
			pulse_b_q <= 1'b0;
			front_q   <= tptf_pkg::PHASE_NONE;
			back_q    <= tptf_pkg::PHASE_NONE;
			gates_q   <= '0;
			delay_q   <= tptf_pkg::FIRING_DELAY_RST;
		end else if (en) begin
			tick_q    <= tick_n;
			cmp_a_q   <= cmp_a_n;
			cmp_b_q   <= cmp_b_n;
			next_b_q  <= next_b_n;
			pulse_a_q <= pulse_a_n;
			pulse_b_q <= pulse_b_n;
			front_q   <= front_n;
			back_q    <= back_n;
			gates_q   <= gates_n;
			delay_q   <= delay_n;
		end
	end

	assign result.gate_one     = gates_n[0];
	assign result.gate_two     = gates_n[1];
	assign result.gate_three   = gates_n[2];
	assign result.delay_in_use = delay_n;

endmodule
`default_nettype wire

FILE: rtl/core/three_phase_triac_firing.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Three-phase TRIAC phase-angle firing controller
// Usage:
//   cmd_ch carries one command per beat: timer tick, zero crossing of a
//   phase, or a potentiometer sample. res_ch returns one beat per command
//   with the three gate levels and the firing delay after that command.
//   cfg_we / cfg_index / cfg_data write pulse width, minimum and maximum
//   delay; write them only while no command is in flight.
//   Path: a command passes through the input register, then the result
//   register, once accepted; a stall can hold it in either.
//   Throughput: one command per cycle while res_ch does not stall, set by the
//   update of the timer, compare channels and phase queue in tptf_fire_step.
//   Reset: timer, channel B, queue and gates clear, compare A goes to 255,
//   the delay to 100 ticks, the registers to defaults; no beat is pending.
//   Stall: a waiting result holds in its register while one more command
//   is taken into the input register; cmd_ch.ready drops only when both
//   are full and res_ch.ready is low.
// ---------------------------------------------------------------------------
module three_phase_triac_firing (
	input  wire logic       clk,
	input  wire logic       arst_n,
	tptf_cmd_if.sink        cmd_ch,
	tptf_res_if.source      res_ch,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	tptf_pkg::cfg_t    cfg;
	tptf_pkg::item_t   item_s1;
	logic              valid_s1;
	tptf_pkg::result_t step_res;
	tptf_pkg::result_t res_s2;
	logic              valid_s2;
	logic              advance;
	logic              accept;

	assign advance      = !valid_s2 || res_ch.ready;
	assign cmd_ch.ready = !valid_s1 || advance;
	assign accept       = cmd_ch.valid && cmd_ch.ready;

	tptf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tptf_fire_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd_ch.ready) valid_s1 <= cmd_ch.valid;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	// hold payload on stall
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command    <= cmd_ch.command;
			item_s1.phase_id   <= cmd_ch.phase_id;
			item_s1.pot_sample <= cmd_ch.pot_sample;
		end
		if (valid_s1 && advance) res_s2 <= step_res;
	end

	assign res_ch.valid        = valid_s2;
	assign res_ch.gate_one     = res_s2.gate_one;
	assign res_ch.gate_two     = res_s2.gate_two;
	assign res_ch.gate_three   = res_s2.gate_three;
	assign res_ch.delay_in_use = res_s2.delay_in_use;

endmodule
`default_nettype wire

FILE: rtl/core/tptf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Three-phase TRIAC firing: port checker
// Timing properties of the command and result channels, bound to the top.
// ---------------------------------------------------------------------------
module tptf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       gate_one,
	input wire logic       gate_two,
	input wire logic       gate_three,
	input wire logic [7:0] delay_in_use
);

	logic in_beat;
	assign in_beat = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gate_one) && $stable(gate_two)
			&& $stable(gate_three) && $stable(delay_in_use))
		else $error("stalled result beat changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!in_beat ##1 (!in_beat && !out_valid) |=> !out_valid)
		else $error("result beat without command");

	a_ready_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("command stalled while result drains");

	a_ready_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("command stalled with empty result register");

endmodule

bind three_phase_triac_firing tptf_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (cmd_ch.valid),
	.in_ready     (cmd_ch.ready),
	.out_valid    (res_ch.valid),
	.out_ready    (res_ch.ready),
	.gate_one     (res_ch.gate_one),
	.gate_two     (res_ch.gate_two),
	.gate_three   (res_ch.gate_three),
	.delay_in_use (res_ch.delay_in_use)
);
`default_nettype wire
